// ----- rtl/blse_pkg.sv -----
// Shared types and constants for the bounded list store engine.
// No dependencies; every other file of the block depends on this package.
package blse_pkg;

    localparam int CAPACITY    = 64;
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = 6;
    localparam int COUNT_W     = 7;
    localparam int ACTION_W    = 3;
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // Action codes on the request channel
    localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SIZE    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REVERSE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_LIST    = 3'd5;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DELETE,
        OP_FIND,
        OP_SIZE,
        OP_REVERSE,
        OP_LIST
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIND    = 2'd0,
        KIND_SIZE    = 2'd1,
        KIND_ENTRY   = 2'd2,
        KIND_REFUSED = 2'd3
    } t_kind;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_kind              kind;
        logic               found;
        logic [COUNT_W-1:0] count;
        logic [DATA_W-1:0]  item;
        logic               last;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } t_state;

endpackage

// ----- rtl/blse_cmd_if.sv -----
// Request channel of the bounded list store engine: valid/ready plus action and value.
// Depends on blse_pkg for field widths.
interface blse_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [blse_pkg::ACTION_W-1:0]       action;
    logic signed [blse_pkg::DATA_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- rtl/blse_rsp_if.sv -----
// Result channel of the bounded list store engine: valid/ready plus result fields.
// Depends on blse_pkg for field widths.
interface blse_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [blse_pkg::KIND_W-1:0]         kind;
    logic                                found;
    logic [blse_pkg::COUNT_W-1:0]        count;
    logic signed [blse_pkg::DATA_W-1:0]  item;
    logic                                last;

    modport source (output valid, output kind, output found, output count,
                    output item, output last, input ready);
    modport sink   (input valid, input kind, input found, input count,
                    input item, input last, output ready);
endinterface

// ----- rtl/blse_front.sv -----
// Front end: accepts requests, decodes the action and registers the decoded request.
// Depends on blse_pkg and blse_cmd_if; feeds blse_queue.
module blse_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    blse_cmd_if.sink           i_cmd,
    output logic               o_req_valid,
    input  logic               i_req_ready,
    output blse_pkg::t_req     o_req
);
    import blse_pkg::*;

    logic r_v;
    t_req r_req;
    logic n_v;
    t_req n_req;
    logic accept;
    logic keep;
    t_op  dec_op;

    assign i_cmd.ready = !r_v || i_req_ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        keep   = 1'b1;
        dec_op = OP_INSERT;
        unique case (i_cmd.action)
            ACT_INSERT:  dec_op = OP_INSERT;
            ACT_DELETE:  dec_op = OP_DELETE;
            ACT_FIND:    dec_op = OP_FIND;
            ACT_SIZE:    dec_op = OP_SIZE;
            ACT_REVERSE: dec_op = OP_REVERSE;
            ACT_LIST:    dec_op = OP_LIST;
            // unused codes are taken and dropped
            default:     keep = 1'b0;
        endcase
    end

    always_comb begin
        n_v   = r_v;
        n_req = r_req;
        if (accept) begin
            n_v   = keep;
            n_req = '{op: dec_op, value: i_cmd.value};
        end else if (i_req_ready) begin
            n_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
    end

    assign o_req_valid = r_v;
    assign o_req       = r_req;

endmodule

// ----- rtl/blse_queue.sv -----
// Short request queue between the front end and the list engine.
// Depends on blse_pkg for the request type and depth.
module blse_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  blse_pkg::t_req     i_push,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output blse_pkg::t_req     o_pop
);
    import blse_pkg::*;

    t_req                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_CW-1:0] r_cnt;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_cnt != QUEUE_CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop        = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QUEUE_CW'(1);
                2'b01:   r_cnt <= r_cnt - QUEUE_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + QUEUE_CW'(1)))
        else $error("queue fill did not follow a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == QUEUE_CW'(QUEUE_DEPTH)) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with fill");

endmodule

// ----- rtl/blse_back.sv -----
// List engine: circular entry store with head pointer and direction, walks for
// delete, find and list, output register towards the result channel.
// Depends on blse_pkg and blse_rsp_if; fed by blse_queue.
module blse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  blse_pkg::t_req     i_req,
    blse_rsp_if.source         o_rsp
);
    import blse_pkg::*;

    // Entry store: logical position p sits at r_head + p (or r_head - p when reversed)
    logic [DATA_W-1:0]   mem [STORE_DEPTH];
    logic [DATA_W-1:0]   r_rd_data;

    t_state              r_state, n_state;
    logic [STORE_AW-1:0] r_head, n_head;
    logic                r_dir, n_dir;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [COUNT_W-1:0]  r_idx, n_idx;
    logic [COUNT_W-1:0]  r_wr, n_wr;
    logic                r_s1_v, n_s1_v;
    logic                r_s1_last, n_s1_last;
    logic                r_hit, n_hit;
    t_op                 r_op, n_op;
    logic [DATA_W-1:0]   r_val, n_val;
    t_rsp                r_resp, n_resp;
    logic                r_out_v, n_out_v;
    t_rsp                r_out, n_out;

    logic                out_free;
    logic                s1_take;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic                we;
    logic [STORE_AW-1:0] wa;
    logic [DATA_W-1:0]   wd;

    function automatic logic [STORE_AW-1:0] f_phys(input logic [STORE_AW-1:0] head,
                                                   input logic dir,
                                                   input logic [STORE_AW-1:0] pos);
        f_phys = dir ? (head - pos) : (head + pos);
    endfunction

    always_comb begin
        out_free = !r_out_v || o_rsp.ready;
        s1_take  = r_s1_v && ((r_op != OP_LIST) || out_free);
        rd_en    = (r_state == ST_WALK) && (r_idx != r_count) && (!r_s1_v || s1_take);
        rd_addr  = f_phys(r_head, r_dir, r_idx[STORE_AW-1:0]);

        n_state   = r_state;
        n_head    = r_head;
        n_dir     = r_dir;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_hit     = r_hit;
        n_op      = r_op;
        n_val     = r_val;
        n_resp    = r_resp;
        n_s1_v    = r_s1_v;
        n_s1_last = r_s1_last;
        n_out_v   = r_out_v && !o_rsp.ready;
        n_out     = r_out;
        we        = 1'b0;
        wa        = f_phys(r_head, r_dir, r_wr[STORE_AW-1:0]);
        wd        = r_rd_data;
        o_req_ready = 1'b0;

        // read issue stage
        if (rd_en) begin
            n_idx     = r_idx + COUNT_W'(1);
            n_s1_v    = 1'b1;
            n_s1_last = (r_idx == r_count - COUNT_W'(1));
        end else if (s1_take) begin
            n_s1_v = 1'b0;
        end

        // read data stage
        if (s1_take) begin
            case (r_op)
                OP_DELETE: begin
                    // keep unequal entries, compacted towards the head
                    if (r_rd_data != r_val) begin
                        we   = 1'b1;
                        n_wr = r_wr + COUNT_W'(1);
                    end
                end
                OP_FIND: begin
                    if (r_rd_data == r_val) begin
                        n_hit = 1'b1;
                    end
                end
                OP_LIST: begin
                    n_out_v = 1'b1;
                    n_out   = '{kind: KIND_ENTRY, found: 1'b0, count: '0,
                                item: r_rd_data, last: r_s1_last};
                end
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_op  = i_req.op;
                    n_val = i_req.value;
                    n_idx = '0;
                    n_wr  = '0;
                    n_hit = 1'b0;
                    unique case (i_req.op)
                        OP_INSERT: begin
                            if (r_count >= COUNT_W'(CAPACITY)) begin
                                n_resp  = '{kind: KIND_REFUSED, found: 1'b0, count: '0,
                                            item: '0, last: 1'b1};
                                n_state = ST_RESP;
                            end else begin
                                // step the head back one place and write there
                                n_head  = r_dir ? (r_head + STORE_AW'(1))
                                                : (r_head - STORE_AW'(1));
                                we      = 1'b1;
                                wa      = n_head;
                                wd      = i_req.value;
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                        OP_SIZE: begin
                            n_resp  = '{kind: KIND_SIZE, found: 1'b0, count: r_count,
                                        item: '0, last: 1'b1};
                            n_state = ST_RESP;
                        end
                        OP_REVERSE: begin
                            if (r_count != '0) begin
                                n_head = f_phys(r_head, r_dir,
                                                r_count[STORE_AW-1:0] - STORE_AW'(1));
                                n_dir  = !r_dir;
                            end
                        end
                        OP_DELETE, OP_LIST: begin
                            if (r_count != '0) begin
                                n_state = ST_WALK;
                            end
                        end
                        OP_FIND: begin
                            if (r_count != '0) begin
                                n_state = ST_WALK;
                            end else begin
                                n_resp  = '{kind: KIND_FIND, found: 1'b0, count: '0,
                                            item: '0, last: 1'b1};
                                n_state = ST_RESP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if ((r_idx == r_count) && !r_s1_v) begin
                    n_state = ST_IDLE;
                    if (r_op == OP_DELETE) begin
                        n_count = r_wr;
                    end else if (r_op == OP_FIND) begin
                        n_resp  = '{kind: KIND_FIND, found: r_hit, count: '0,
                                    item: '0, last: 1'b1};
                        n_state = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_v = 1'b1;
                    n_out   = r_resp;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_dir   <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
            r_wr    <= '0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_dir   <= n_dir;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_wr    <= n_wr;
            r_s1_v  <= n_s1_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= n_s1_last;
        r_hit     <= n_hit;
        r_op      <= n_op;
        r_val     <= n_val;
        r_resp    <= n_resp;
        r_out     <= n_out;
    end

    // hold read data while the data stage is stalled
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_rsp.valid = r_out_v;
    assign o_rsp.kind  = r_out.kind;
    assign o_rsp.found = r_out.found;
    assign o_rsp.count = r_out.count;
    assign o_rsp.item  = r_out.item;
    assign o_rsp.last  = r_out.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_s1_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> (r_state == ST_WALK))
        else $error("read data pending outside a walk");

    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ((r_wr <= r_idx) && (r_idx <= r_count)))
        else $error("delete write position overtook read position");

endmodule

// ----- rtl/bounded_list_store_engine.sv -----
// Top level of the bounded list store engine: front end, request queue and list engine.
// Depends on blse_pkg, blse_cmd_if, blse_rsp_if, blse_front, blse_queue, blse_back.
//
//  port      dir  payload                          handshake
//  i_cmd     in   action[2:0], value[31:0] signed   valid/ready
//  o_rsp     out  kind, found, count, item, last    valid/ready
//
// Insert, size and reverse are handled without a walk; delete, find and list walk the
// entries held, set by the single read port of the entry store, one entry per cycle
// while the result channel does not stall a list walk.
// Requests queue up in front (four deep plus one decode register) while the engine works.
// Reset is synchronous and active low; it empties the list, no clearing pass.
// A stalled result channel holds a list walk in place without losing entries.
module bounded_list_store_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blse_cmd_if.sink   i_cmd,
    blse_rsp_if.source o_rsp
);
    import blse_pkg::*;

    logic f_valid;
    logic f_ready;
    t_req f_req;
    logic q_valid;
    logic q_ready;
    t_req q_req;

    blse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_req_valid (f_valid),
        .i_req_ready (f_ready),
        .o_req       (f_req)
    );

    blse_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push       (f_req),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop        (q_req)
    );

    blse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (q_valid),
        .o_req_ready (q_ready),
        .i_req       (q_req),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bounded_list_store_engine: directed table, then random list traffic.
// Depends on blse_pkg, blse_cmd_if, blse_rsp_if and the engine RTL.
module tb_top;
    import blse_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;
    localparam int RANDOM_REQS = 300;
    localparam int CALM_REQS   = 60;
    localparam int TAIL_CYCLES = 120;

    typedef enum {CHK_MODEL, CHK_NOTHING, CHK_ONE} t_row_chk;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   value;
        int                  reps;
        t_row_chk            chk;
        t_rsp                want;
    } t_plan_row;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   calm  = 1'b0;
    int   faults = 0;

    logic [DATA_W-1:0] shadow_list [$];
    t_rsp              fresh_rsp [$];
    t_rsp              owed_results [$];
    t_plan_row         plan [$];
    logic [DATA_W-1:0] value_pool [8];

    blse_cmd_if cmd_ch ();
    blse_rsp_if rsp_ch ();

    bounded_list_store_engine u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_rsp make_rsp(input t_kind kind, input logic found,
                                      input logic [COUNT_W-1:0] count,
                                      input logic [DATA_W-1:0] item);
        t_rsp r;
        r.kind  = kind;
        r.found = found;
        r.count = count;
        r.item  = item;
        r.last  = 1'b1;
        return r;
    endfunction

    // Update the shadow list for one request and collect the results it causes.
    function automatic void apply_list_command(input logic [ACTION_W-1:0] act,
                                               input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] kept [$];
        logic [DATA_W-1:0] tmp;
        t_rsp r;
        bit   hit;
        int   n;
        fresh_rsp.delete();
        n = shadow_list.size();
        case (act)
            ACT_INSERT: begin
                if (n >= CAPACITY)
                    fresh_rsp.push_back(make_rsp(KIND_REFUSED, 1'b0, '0, '0));
                else
                    shadow_list.push_front(val);
            end
            ACT_DELETE: begin
                foreach (shadow_list[i])
                    if (shadow_list[i] != val) kept.push_back(shadow_list[i]);
                shadow_list = kept;
            end
            ACT_FIND: begin
                hit = 1'b0;
                foreach (shadow_list[i])
                    if (shadow_list[i] == val) hit = 1'b1;
                fresh_rsp.push_back(make_rsp(KIND_FIND, hit, '0, '0));
            end
            ACT_SIZE: fresh_rsp.push_back(make_rsp(KIND_SIZE, 1'b0, COUNT_W'(n), '0));
            ACT_REVERSE: begin
                for (int i = 0; i < n / 2; i++) begin
                    tmp                = shadow_list[i];
                    shadow_list[i]     = shadow_list[n-1-i];
                    shadow_list[n-1-i] = tmp;
                end
            end
            ACT_LIST: begin
                for (int i = 0; i < n; i++) begin
                    r      = make_rsp(KIND_ENTRY, 1'b0, '0, shadow_list[i]);
                    r.last = (i == n - 1);
                    fresh_rsp.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 18);
    endfunction

    // Present one request, hold it until accepted, then record what it owes.
    task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val,
                            input t_row_chk chk, input t_rsp want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= act;
        cmd_ch.value  <= val;
        do @(posedge clk); while (!cmd_ch.ready);
        apply_list_command(act, val);
        case (chk)
            CHK_MODEL: foreach (fresh_rsp[i]) owed_results.push_back(fresh_rsp[i]);
            CHK_ONE:   owed_results.push_back(want);
            default:   ;
        endcase
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (owed_results.size() != 0);
    endtask

    function automatic logic [ACTION_W-1:0] pick_action(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)                return (r < 2) ? ACT_SPARE_A : ACT_SPARE_B;
        if (r < (grow ? 63 : 18)) return ACT_INSERT;
        if (r < (grow ? 68 : 58)) return ACT_DELETE;
        if (r < (grow ? 80 : 73)) return ACT_FIND;
        if (r < (grow ? 87 : 83)) return ACT_SIZE;
        if (r < (grow ? 93 : 90)) return ACT_REVERSE;
        return ACT_LIST;
    endfunction

    // Favour values already held or drawn from a small pool, so finds hit and deletes bite.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return value_pool[$urandom_range(0, 7)];
        if (r < 8 && shadow_list.size() != 0)
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        return $urandom;
    endfunction

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            faults++;
        end
    endtask

    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result: kind %0d item %h", rsp_ch.kind, rsp_ch.item);
                faults++;
            end else begin
                want = owed_results.pop_front();
                compare_field("kind",  DATA_W'(want.kind),  DATA_W'(rsp_ch.kind));
                compare_field("found", DATA_W'(want.found), DATA_W'(rsp_ch.found));
                compare_field("count", DATA_W'(want.count), DATA_W'(rsp_ch.count));
                compare_field("item",  want.item,           rsp_ch.item);
                compare_field("last",  DATA_W'(want.last),  DATA_W'(rsp_ch.last));
            end
        end
    end

    // Result side: random stall bursts, always ready once the run settles.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            if (calm) begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end else if ($urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial begin
        t_rsp              none;
        logic [ACTION_W-1:0] act;
        int                issued;
        int                seg_left;
        bit                grow;
        bit                paused;

        none = '0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.action <= ACT_INSERT;
        cmd_ch.value  <= '0;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

        // Empty list first, then extremes, duplicates, spare codes and a fill past capacity.
        plan.push_back('{ACT_SIZE,    32'd0,          1,  CHK_ONE,
                         make_rsp(KIND_SIZE, 1'b0, 7'd0, '0)});
        plan.push_back('{ACT_LIST,    32'd0,          1,  CHK_NOTHING, none});
        plan.push_back('{ACT_FIND,    32'd0,          1,  CHK_ONE,
                         make_rsp(KIND_FIND, 1'b0, '0, '0)});
        plan.push_back('{ACT_REVERSE, 32'd0,          1,  CHK_NOTHING, none});
        plan.push_back('{ACT_DELETE,  32'd5,          1,  CHK_NOTHING, none});
        plan.push_back('{ACT_INSERT,  32'h7fff_ffff,  1,  CHK_NOTHING, none});
        plan.push_back('{ACT_INSERT,  32'h8000_0000,  1,  CHK_NOTHING, none});
        plan.push_back('{ACT_INSERT,  32'h0000_0000,  1,  CHK_NOTHING, none});
        plan.push_back('{ACT_INSERT,  32'hffff_ffff,  1,  CHK_NOTHING, none});
        plan.push_back('{ACT_FIND,    32'h8000_0000,  1,  CHK_ONE,
                         make_rsp(KIND_FIND, 1'b1, '0, '0)});
        plan.push_back('{ACT_SIZE,    32'd0,          1,  CHK_ONE,
                         make_rsp(KIND_SIZE, 1'b0, 7'd4, '0)});
        plan.push_back('{ACT_REVERSE, 32'd0,          1,  CHK_MODEL,   none});
        plan.push_back('{ACT_LIST,    32'd0,          1,  CHK_MODEL,   none});
        plan.push_back('{ACT_INSERT,  32'h0000_0000,  1,  CHK_NOTHING, none});
        plan.push_back('{ACT_DELETE,  32'h0000_0000,  1,  CHK_MODEL,   none});
        plan.push_back('{ACT_FIND,    32'h0000_0000,  1,  CHK_ONE,
                         make_rsp(KIND_FIND, 1'b0, '0, '0)});
        plan.push_back('{ACT_SPARE_A, 32'hffff_ffff,  1,  CHK_NOTHING, none});
        plan.push_back('{ACT_SPARE_B, 32'h0000_0000,  1,  CHK_NOTHING, none});
        plan.push_back('{ACT_INSERT,  32'h0000_1000,  64, CHK_MODEL,   none});
        plan.push_back('{ACT_INSERT,  32'h1234_5678,  1,  CHK_ONE,
                         make_rsp(KIND_REFUSED, 1'b0, '0, '0)});
        plan.push_back('{ACT_SIZE,    32'd0,          1,  CHK_ONE,
                         make_rsp(KIND_SIZE, 1'b0, 7'd64, '0)});
        plan.push_back('{ACT_LIST,    32'd0,          1,  CHK_MODEL,   none});
        plan.push_back('{ACT_REVERSE, 32'd0,          1,  CHK_MODEL,   none});
        plan.push_back('{ACT_LIST,    32'd0,          1,  CHK_MODEL,   none});
        plan.push_back('{ACT_DELETE,  32'h7fff_ffff,  1,  CHK_MODEL,   none});
        plan.push_back('{ACT_FIND,    32'h7fff_ffff,  1,  CHK_ONE,
                         make_rsp(KIND_FIND, 1'b0, '0, '0)});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
            for (int k = 0; k < plan[r].reps; k++)
                send_cmd(plan[r].action, plan[r].value + k, plan[r].chk, plan[r].want);
        drain_results();

        issued   = 0;
        seg_left = 0;
        grow     = 1'b0;
        paused   = 1'b0;
        while (issued < RANDOM_REQS) begin
            if (seg_left == 0) begin
                grow     = !grow;
                seg_left = grow ? $urandom_range(30, 90) : $urandom_range(10, 30);
            end
            seg_left--;
            if (issued >= RANDOM_REQS - CALM_REQS) calm = 1'b1;
            if (issued == RANDOM_REQS / 2 && !paused) begin
                paused = 1'b1;
                drain_results();
            end
            act = pick_action(grow);
            send_cmd(act, pick_value(), CHK_MODEL, none);
            if (act != ACT_SPARE_A && act != ACT_SPARE_B) issued++;
        end

        // Close with a size request so that all earlier work has finished.
        send_cmd(ACT_SIZE, $urandom, CHK_MODEL, none);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0 && owed_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/blse_pkg.sv
rtl/blse_cmd_if.sv
rtl/blse_rsp_if.sv
rtl/blse_front.sv
rtl/blse_queue.sv
rtl/blse_back.sv
rtl/bounded_list_store_engine.sv
tb/tb_top.sv
